// ----- rtl/dual_cascaded_dma_controller_unit_assert.svh -----
// Assertion macros shared by the controller's RTL.
`ifndef DUAL_CASCADED_DMA_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_CASCADED_DMA_CONTROLLER_UNIT_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define DCD_ASSERT_NOW(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// The condition holds in the cycle after the trigger.
`define DCD_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- rtl/dcd_pkg.sv -----
package dcd_pkg;

   localparam int unsigned BUFFER_BYTES = 512;
   localparam int unsigned CHAN_DEPTH = 8;
   localparam int unsigned SPARE_DEPTH = 16;

   localparam logic [1:0] MODE_READ = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_REQ = 2'd2;
   localparam logic [1:0] MODE_GRANT = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_BLOCK = 2'd1;
   localparam logic [1:0] ERR_BOUND = 2'd2;

   localparam logic [2:0] REG_STATUS = 3'd0;
   localparam logic [2:0] REG_REQUEST = 3'd1;
   localparam logic [2:0] REG_SMASK = 3'd2;
   localparam logic [2:0] REG_MODE = 3'd3;
   localparam logic [2:0] REG_FLIPFLOP = 3'd4;
   localparam logic [2:0] REG_CLEAR = 3'd5;
   localparam logic [2:0] REG_UNMASK = 3'd6;
   localparam logic [2:0] REG_MASK = 3'd7;

   localparam logic [2:0] HS_HRQ = 3'd1;
   localparam logic [2:0] HS_HLDA = 3'd2;
   localparam logic [2:0] HS_TC = 3'd4;

   localparam logic [3:0] PAGE_SPARE = 4'd8;
   localparam logic [3:0] PAGE_MAP [8] = '{4'd8, 4'd2, 4'd3, 4'd1, 4'd8, 4'd8, 4'd8, 4'd0};

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] port;
      logic [7:0] wdata;
      logic [2:0] req_channel;
      logic       req_level;
      logic [9:0] moved_units;
   } req_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        port_unclaimed;
      logic        hold_request;
      logic        granted;
      logic [2:0]  grant_channel;
      logic [23:0] phys_address;
      logic [9:0]  max_bytes;
      logic [1:0]  xfer_kind;
      logic        terminal_count;
      logic [1:0]  request_error;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  chan_mode;
      logic [7:0]  page_byte;
      logic [15:0] base_addr;
      logic [15:0] curr_addr;
      logic [15:0] base_cnt;
      logic [15:0] curr_cnt;
   } rec_type;

   typedef struct packed {
      logic [1:0][7:0] st;
      logic [1:0][3:0] mk;
      logic [1:0][7:0] cmd;
      logic [1:0]      off;
      logic [1:0]      tg;
      logic [1:0][3:0] rq;
      logic [1:0][3:0] ak;
      logic [2:0]      hs;
      logic [1:0]      err;
   } glb_type;

   typedef struct packed {
      logic       is_ac;
      logic       ac_k;
      logic [1:0] ac_c;
      logic       ac_cnt;
      logic       is_pg;
      logic       pg_spare;
      logic [2:0] pg_ch;
      logic       is_ctl;
      logic       ctl_k;
      logic [2:0] ctl_r;
   } pdec_type;

endpackage

// ----- rtl/dcd_ram.sv -----
module dcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/dual_cascaded_dma_controller_unit.sv -----
// Each accepted beat steps through S_CAS and then S_CHAN; the result is registered as S_CHAN ends.
// A new beat is accepted only in idle; busy covers the two channel memory reads
// (cascade channel, then the addressed channel) and the write-back.
// Reset is synchronous and active high; the channel and spare page memories read
// as zero until written, tracked by per-entry valid flops that reset clears at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "dual_cascaded_dma_controller_unit_assert.svh"

module dual_cascaded_dma_controller_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dcd_pkg::req_type req_item,
   output logic             rsp_valid,
   output dcd_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);

   // Sequencer states. In S_CAS the cascade channel record arrives, in S_CHAN
   // the addressed channel record arrives and the whole beat is resolved.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CAS = 2'd1;
   localparam logic [1:0] S_CHAN = 2'd2;

   localparam int unsigned CW = $clog2(dcd_pkg::CHAN_DEPTH);
   localparam int unsigned SW = $clog2(dcd_pkg::SPARE_DEPTH);

   // Controller state after reset: every channel masked, everything else clear.
   localparam dcd_pkg::glb_type G_RESET = '{st: '0, mk: '1, cmd: '0, off: '0, tg: '0,
                                            rq: '0, ak: '0, hs: '0, err: '0};

   // Fixed-priority pick over the requesting, unmasked channels; 4 means none.
   function automatic logic [2:0] pick(input logic [7:0] st, input logic [3:0] mk);
      logic [2:0] c;
      c = 3'd4;
      for (int i = 3; i >= 0; i--) begin
         if (st[i+4] && !mk[i]) c = 3'(i);
      end
      return c;
   endfunction

   // Hold request logic of the 16-bit controller.
   function automatic dcd_pkg::glb_type f_upper(input dcd_pkg::glb_type g);
      dcd_pkg::glb_type r;
      r = g;
      if (!r.off[1]) begin
         if (r.st[1][7:4] == 4'd0) r.hs[0] = 1'b0;
         else if (pick(r.st[1], r.mk[1]) != 3'd4) r.hs[0] = 1'b1;
      end
      return r;
   endfunction

   // The 8-bit controller drives the request line of channel 4.
   function automatic dcd_pkg::glb_type f_cascade(input dcd_pkg::glb_type g,
         input logic val, input logic conn4, input logic [5:0] md4);
      dcd_pkg::glb_type r;
      r = g;
      r.rq[1][0] = val;
      if (conn4) begin
         if (!val) begin
            r.st[1][4] = 1'b0;
            r = f_upper(r);
         end else begin
            r.st[1][4] = 1'b1;
            if (md4[5:4] == 2'd2) r.err = dcd_pkg::ERR_BLOCK;
            else r = f_upper(r);
         end
      end
      return r;
   endfunction

   function automatic dcd_pkg::glb_type f_lower(input dcd_pkg::glb_type g,
         input logic conn4, input logic [5:0] md4);
      dcd_pkg::glb_type r;
      r = g;
      if (!r.off[0]) begin
         if (r.st[0][7:4] == 4'd0) r = f_cascade(r, 1'b0, conn4, md4);
         else if (pick(r.st[0], r.mk[0]) != 3'd4) r = f_cascade(r, 1'b1, conn4, md4);
      end
      return r;
   endfunction

   function automatic dcd_pkg::glb_type f_hrq(input dcd_pkg::glb_type g, input logic k,
         input logic conn4, input logic [5:0] md4);
      return k ? f_upper(g) : f_lower(g, conn4, md4);
   endfunction

   function automatic dcd_pkg::pdec_type port_dec(input logic [7:0] p);
      dcd_pkg::pdec_type d;
      logic [3:0] m;
      m = dcd_pkg::PAGE_MAP[p[2:0]];
      d.is_ac = (p < 8'h08) || (p >= 8'hc0 && p <= 8'hce && !p[0]);
      d.ac_k = (p >= 8'hc0);
      d.ac_c = d.ac_k ? p[3:2] : p[2:1];
      d.ac_cnt = d.ac_k ? p[1] : p[0];
      d.is_pg = (p[7:4] == 4'h8);
      d.pg_spare = (m == dcd_pkg::PAGE_SPARE);
      d.pg_ch = {p[3], m[1:0]};
      d.ctl_k = (p >= 8'hd0);
      d.is_ctl = (p >= 8'h08 && p <= 8'h0f) || (p >= 8'hd0 && p <= 8'hde && !p[0]);
      d.ctl_r = d.ctl_k ? p[3:1] : p[2:0];
      return d;
   endfunction

   logic [1:0]       state_ff, state_in;
   dcd_pkg::req_type req_ff;
   logic [CW-1:0]    prim_ff, prim_in;
   logic [5:0]       md4_ff;
   dcd_pkg::glb_type g_ff, g_in;
   logic [7:0]       conn_ff;
   logic [dcd_pkg::CHAN_DEPTH-1:0]  rec_vld_ff;
   logic [dcd_pkg::SPARE_DEPTH-1:0] sp_vld_ff;
   logic             rdv_ff, spv_ff;
   logic             rsp_valid_ff;
   dcd_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    ram_raddr;
   logic [$bits(dcd_pkg::rec_type)-1:0] ram_rdata;
   dcd_pkg::rec_type rec_rd, rec_wr;
   logic [7:0]       sp_rdata, sp_rd;
   logic             sp_we;
   logic             accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   // In idle the cascade channel is addressed; afterwards the addressed channel.
   assign ram_raddr = (state_ff == S_IDLE) ? CW'(4) : prim_ff;
   assign rec_rd = rdv_ff ? dcd_pkg::rec_type'(ram_rdata) : '0;
   assign sp_rd = spv_ff ? sp_rdata : 8'h00;

   dcd_ram #(
      .WIDTH($bits(dcd_pkg::rec_type)),
      .DEPTH(dcd_pkg::CHAN_DEPTH)
   ) u_chan_ram (
      .clock(clock),
      .we(state_ff == S_CHAN),
      .waddr(prim_ff),
      .wdata(rec_wr),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   dcd_ram #(
      .WIDTH(8),
      .DEPTH(dcd_pkg::SPARE_DEPTH)
   ) u_spare_ram (
      .clock(clock),
      .we(sp_we),
      .waddr(req_ff.port[SW-1:0]),
      .wdata(req_ff.wdata),
      .raddr(accept ? req_item.port[SW-1:0] : req_ff.port[SW-1:0]),
      .rdata(sp_rdata)
   );

   // Channel that the accepted beat addresses, taken from the port decode, from the
   // request channel of a request beat, or from the priority pick of the grant.
   always_comb begin
      dcd_pkg::pdec_type pd;
      logic [2:0] c1, c0;
      pd = port_dec(req_item.port);
      c1 = pick(g_ff.st[1], g_ff.mk[1]);
      c0 = pick(g_ff.st[0], g_ff.mk[0]);
      prim_in = '0;
      case (req_item.mode) inside
         dcd_pkg::MODE_READ, dcd_pkg::MODE_WRITE: begin
            if (pd.is_ac) prim_in = CW'({pd.ac_k, pd.ac_c});
            else if (pd.is_pg) prim_in = CW'(pd.pg_ch);
            else if (pd.is_ctl && pd.ctl_r == dcd_pkg::REG_MODE)
               prim_in = CW'({pd.ctl_k, req_item.wdata[1:0]});
         end
         dcd_pkg::MODE_REQ: prim_in = CW'(req_item.req_channel);
         default: begin
            if (c1 == 3'd0) prim_in = CW'({1'b0, c0[1:0]});
            else prim_in = CW'({1'b1, c1[1:0]});
         end
      endcase
   end

   // Resolution of one beat against the addressed channel record.
   always_comb begin
      dcd_pkg::glb_type g;
      dcd_pkg::rec_type r;
      dcd_pkg::pdec_type pd;
      logic k, gk;
      logic [1:0] c;
      logic [2:0] pc;
      logic [15:0] v, len, ncnt;
      logic [31:0] base, span, roof, msk, maxlen;
      logic tc;
      g = g_ff;
      r = rec_rd;
      pd = port_dec(req_ff.port);
      rsp_in = '0;
      sp_we = 1'b0;
      k = 1'b0;
      c = 2'd0;
      v = 16'd0;
      base = 32'd0;
      span = 32'd0;
      roof = 32'd0;
      msk = 32'd0;
      maxlen = 32'd0;
      tc = 1'b0;
      len = 16'd0;
      ncnt = 16'd0;
      gk = 1'b1;
      pc = 3'd4;
      g.err = dcd_pkg::ERR_NONE;
      case (req_ff.mode)
         dcd_pkg::MODE_READ: begin
            if (pd.is_ac) begin
               v = pd.ac_cnt ? r.curr_cnt : r.curr_addr;
               rsp_in.rdata = g.tg[pd.ac_k] ? v[15:8] : v[7:0];
               g.tg[pd.ac_k] = !g.tg[pd.ac_k];
            end else if (pd.is_pg) begin
               rsp_in.rdata = pd.pg_spare ? sp_rd : r.page_byte;
            end else if (pd.is_ctl && pd.ctl_r == dcd_pkg::REG_STATUS) begin
               rsp_in.rdata = g.st[pd.ctl_k];
               g.st[pd.ctl_k][3:0] = 4'd0;
            end else if (pd.is_ctl && pd.ctl_r == dcd_pkg::REG_CLEAR) begin
               rsp_in.rdata = 8'h00;
            end else if (pd.is_ctl && pd.ctl_r == dcd_pkg::REG_MASK) begin
               rsp_in.rdata = {4'hf, g.mk[pd.ctl_k]};
            end else begin
               rsp_in.rdata = 8'hff;
               rsp_in.port_unclaimed = 1'b1;
            end
         end
         dcd_pkg::MODE_WRITE: begin
            if (pd.is_ac) begin
               if (pd.ac_cnt) begin
                  if (!g.tg[pd.ac_k]) begin
                     r.base_cnt = {8'h00, req_ff.wdata};
                     r.curr_cnt = {8'h00, req_ff.wdata};
                  end else begin
                     r.base_cnt = r.base_cnt | {req_ff.wdata, 8'h00};
                     r.curr_cnt = r.curr_cnt | {req_ff.wdata, 8'h00};
                  end
               end else begin
                  if (!g.tg[pd.ac_k]) begin
                     r.base_addr = {8'h00, req_ff.wdata};
                     r.curr_addr = {8'h00, req_ff.wdata};
                  end else begin
                     r.base_addr = r.base_addr | {req_ff.wdata, 8'h00};
                     r.curr_addr = r.curr_addr | {req_ff.wdata, 8'h00};
                  end
               end
               g.tg[pd.ac_k] = !g.tg[pd.ac_k];
            end else if (pd.is_pg) begin
               // The spare page byte is written once, when the beat resolves.
               if (pd.pg_spare) sp_we = (state_ff == S_CHAN);
               else r.page_byte = req_ff.wdata;
            end else if (pd.is_ctl) begin
               k = pd.ctl_k;
               c = req_ff.wdata[1:0];
               unique case (pd.ctl_r)
                  dcd_pkg::REG_STATUS: begin
                     g.cmd[k] = req_ff.wdata;
                     g.off[k] = req_ff.wdata[2];
                     g = f_hrq(g, k, conn_ff[4], md4_ff);
                  end
                  dcd_pkg::REG_REQUEST: begin
                     g.st[k][{1'b1, c}] = req_ff.wdata[2];
                     g = f_hrq(g, k, conn_ff[4], md4_ff);
                  end
                  dcd_pkg::REG_SMASK: begin
                     g.mk[k][c] = req_ff.wdata[2];
                     g = f_hrq(g, k, conn_ff[4], md4_ff);
                  end
                  dcd_pkg::REG_MODE: r.chan_mode = req_ff.wdata[7:2];
                  dcd_pkg::REG_FLIPFLOP: g.tg[k] = 1'b0;
                  dcd_pkg::REG_CLEAR: begin
                     g.mk[k] = 4'hf;
                     g.off[k] = 1'b0;
                     g.cmd[k] = 8'h00;
                     g.st[k] = 8'h00;
                     g.tg[k] = 1'b0;
                  end
                  dcd_pkg::REG_UNMASK: begin
                     g.mk[k] = 4'h0;
                     g = f_hrq(g, k, conn_ff[4], md4_ff);
                  end
                  default: begin
                     g.mk[k] = req_ff.wdata[3:0];
                     g = f_hrq(g, k, conn_ff[4], md4_ff);
                  end
               endcase
            end
         end
         dcd_pkg::MODE_REQ: begin
            k = req_ff.req_channel[2];
            c = req_ff.req_channel[1:0];
            g.rq[k][c] = req_ff.req_level;
            if (conn_ff[req_ff.req_channel]) begin
               if (!req_ff.req_level) begin
                  g.st[k][{1'b1, c}] = 1'b0;
                  g = f_hrq(g, k, conn_ff[4], md4_ff);
               end else begin
                  g.st[k][{1'b1, c}] = 1'b1;
                  base = {8'h00, r.page_byte, 16'h0000} | ({16'h0000, r.base_addr} << k);
                  span = {16'h0000, r.base_cnt} << k;
                  roof = r.chan_mode[3] ? base - span : base + span;
                  msk = 32'h7fff0000 << k;
                  if (r.chan_mode[5:4] == 2'd2) g.err = dcd_pkg::ERR_BLOCK;
                  else if (c != 2'd0 && (base & msk) != (roof & msk))
                     g.err = dcd_pkg::ERR_BOUND;
                  else g = f_hrq(g, k, conn_ff[4], md4_ff);
               end
            end
         end
         default: begin
            // Bus grant: serve the winning channel, stepping through the cascade.
            g.hs = g.hs | dcd_pkg::HS_HLDA;
            pc = pick(g.st[1], g.mk[1]);
            if (pc == 3'd0) begin
               g.ak[1][0] = 1'b1;
               pc = pick(g.st[0], g.mk[0]);
               gk = 1'b0;
            end
            if (pc != 3'd4) begin
               c = pc[1:0];
               rsp_in.granted = 1'b1;
               rsp_in.grant_channel = {gk, c};
               rsp_in.phys_address = {r.page_byte, 16'h0000} | ({8'h00, r.curr_addr} << gk);
               if (!r.chan_mode[3]) begin
                  maxlen = ({16'h0000, r.curr_cnt} + 32'd1) << gk;
                  tc = (maxlen <= 32'(dcd_pkg::BUFFER_BYTES));
                  if (!tc) maxlen = 32'(dcd_pkg::BUFFER_BYTES);
               end else begin
                  tc = (r.curr_cnt == 16'd0);
                  maxlen = 32'd1 << gk;
               end
               if (tc) g.hs = g.hs | dcd_pkg::HS_TC;
               else g.hs = g.hs & ~dcd_pkg::HS_TC;
               rsp_in.max_bytes = maxlen[9:0];
               rsp_in.xfer_kind = r.chan_mode[1:0];
               rsp_in.terminal_count = tc;
               // An undefined transfer type counts a single unit.
               len = (r.chan_mode[1:0] == 2'd3) ? 16'd1 : {6'd0, req_ff.moved_units};
               g.ak[gk][c] = 1'b1;
               if (!r.chan_mode[3]) r.curr_addr = r.curr_addr + len;
               else r.curr_addr = r.curr_addr - 16'd1;
               ncnt = r.curr_cnt - len;
               r.curr_cnt = ncnt;
               // Expiry only when the count lands exactly on all ones.
               if (ncnt == 16'hffff) begin
                  g.st[gk][c] = 1'b1;
                  if (!r.chan_mode[2]) g.mk[gk][c] = 1'b1;
                  else begin
                     r.curr_addr = r.base_addr;
                     r.curr_cnt = r.base_cnt;
                  end
                  g.hs = 3'd0;
                  g.ak[gk][c] = 1'b0;
                  if (!gk) begin
                     g = f_cascade(g, 1'b0, conn_ff[4], md4_ff);
                     g.ak[1][0] = 1'b0;
                  end
               end
            end
         end
      endcase
      rsp_in.hold_request = g.hs[0];
      rsp_in.request_error = g.err;
      g_in = g;
      rec_wr = r;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_CAS;
         S_CAS: state_in = S_CHAN;
         S_CHAN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         conn_ff <= 8'h10;
         g_ff <= G_RESET;
         rec_vld_ff <= '0;
         sp_vld_ff <= '0;
         rdv_ff <= 1'b0;
         spv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == S_CHAN);
         rdv_ff <= rec_vld_ff[ram_raddr];
         spv_ff <= sp_vld_ff[accept ? req_item.port[SW-1:0] : req_ff.port[SW-1:0]];
         if (csr_we) conn_ff <= csr_wdata;
         if (state_ff == S_CHAN) begin
            g_ff <= g_in;
            rec_vld_ff[prim_ff] <= 1'b1;
         end
         if (sp_we) sp_vld_ff[req_ff.port[SW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
         prim_ff <= prim_in;
      end
      if (state_ff == S_CAS) md4_ff <= rec_rd.chan_mode;
      if (state_ff == S_CHAN) rsp_ff <= rsp_in;
   end

   // A result strobe only ever appears once the sequencer is back in idle.
   `DCD_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result strobe while busy")
   // An accepted beat always occupies the sequencer in the next cycle.
   `DCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat not taken up")
   // Every resolved beat produces exactly one result strobe.
   `DCD_ASSERT_NEXT(a_chan_rsp, state_ff == S_CHAN, rsp_valid, "resolved beat lost")

endmodule
